[rtl/phr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Packed HSL to RGB - shared definitions
// Field widths, fixed-point scaling and segment codes for the colour pipeline.
// ----------------------------------------------------------------------------
package phr_pkg;

	localparam int FRAC_BITS_DEF = 24;

	localparam int COLOR_W = 16;
	localparam int SHADE_W = 8;
	localparam int CHAN_W  = 8;

	localparam int HUE_LSB = 10;
	localparam int HUE_W   = 6;
	localparam int SAT_LSB = 7;
	localparam int SAT_W   = 3;
	localparam int LIGHT_W = 7;

	// chroma terms a, b and a-b are whole multiples of 2^(FRAC_BITS-11)
	localparam int UNIT_SHIFT = 11;
	localparam int CHROMA_W   = 11;
	localparam int OPX_W      = 14;

	localparam int N_CHAN   = 3;
	localparam int CH_RED   = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 2;

	typedef enum logic [1:0] {
		SEG_RISE,
		SEG_HIGH,
		SEG_FALL,
		SEG_LOW
	} seg_t;

endpackage
`default_nettype wire

[rtl/phr_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Packed HSL to RGB - stream interfaces
// Valid/ready channels for packed HSL words in and RGB words out.
// ----------------------------------------------------------------------------
interface phr_in_if;
	import phr_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [COLOR_W-1:0]        color_word;
	logic signed [SHADE_W-1:0] shade_offset;

	modport source (output valid, output color_word, output shade_offset, input ready);
	modport sink   (input valid, input color_word, input shade_offset, output ready);
endinterface

interface phr_out_if;
	import phr_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] red;
	logic [CHAN_W-1:0] green;
	logic [CHAN_W-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);
endinterface
`default_nettype wire

[rtl/packed_hsl_to_rgb.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Packed HSL to RGB converter
// Five-stage pipeline turning a packed HSL word plus shade into 8-bit RGB.
// ----------------------------------------------------------------------------
// Usage:
//   hsl : input words, color_word (hue 15..10, sat 9..7, lightness 6..0)
//         and a signed shade_offset added to lightness.
//   rgb : output words, red, green and blue, one per input word.
// A word passes through five register stages, s1 to s5, and shows on rgb
// from the output register. Throughput is one word per cycle while rgb.ready
// does not stall the output.
// Stages: clamp lightness, chroma and hue offsets, segment select,
// multiply, offset and saturate into the output register.
// Each stage advances when its successor is empty or moving, so bubbles
// close up and hsl.ready stays high while stages ahead are free, even
// with a word held at the output.
// A stalled rgb.ready holds the output word and fills the pipeline; nothing
// is dropped or repeated. Reset clears every valid bit, the payload keeps
// whatever it held.
// ----------------------------------------------------------------------------
module packed_hsl_to_rgb #(
	parameter int FRAC_BITS = phr_pkg::FRAC_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	phr_in_if.sink     hsl,
	phr_out_if.source  rgb
);
	import phr_pkg::*;

	localparam int TW       = FRAC_BITS + 1;
	localparam longint unsigned ONE_L = 64'd1 << FRAC_BITS;
	localparam logic [TW-1:0] ONE        = TW'(ONE_L);
	localparam logic [TW-1:0] THIRD      = TW'(ONE_L / 3);
	localparam logic [TW-1:0] TWO_THIRDS = TW'((2 * ONE_L) / 3);
	localparam int PROD_W   = OPX_W + TW;
	localparam int PQ_W     = PROD_W - UNIT_SHIFT;
	localparam int VW       = PQ_W + 3;
	localparam int UNIT_POS = FRAC_BITS - UNIT_SHIFT;
	localparam int BYTE_POS = FRAC_BITS - CHAN_W;
	localparam int H_POS    = FRAC_BITS - LIGHT_W;

	// handshake
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic adv1, adv2, adv3, adv4, adv5;

	assign adv5 = !valid_s5 || rgb.ready;
	assign adv4 = !valid_s4 || adv5;
	assign adv3 = !valid_s3 || adv4;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;

	assign hsl.ready = adv1;
	assign rgb.valid = valid_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= hsl.valid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
			if (adv4) valid_s4 <= valid_s3;
			if (adv5) valid_s5 <= valid_s4;
		end
	end

	// stage 1: unpack, clamp lightness
	logic signed [9:0]    light_sum;
	logic [LIGHT_W-1:0]   light_clamp;
	logic [HUE_W-1:0]     hue_s1;
	logic [SAT_W:0]       sat_s1;
	logic [LIGHT_W-1:0]   light_s1;

	always_comb begin
		light_sum = $signed({3'b000, hsl.color_word[LIGHT_W-1:0]})
			+ $signed({{2{hsl.shade_offset[SHADE_W-1]}}, hsl.shade_offset});
		if (light_sum[9])
			light_clamp = '0;
		else if (light_sum > 10'sd127)
			light_clamp = '1;
		else
			light_clamp = light_sum[LIGHT_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			hue_s1   <= hsl.color_word[HUE_LSB +: HUE_W];
			sat_s1   <= {hsl.color_word[SAT_LSB +: SAT_W], 1'b1};
			light_s1 <= light_clamp;
		end
	end

	// stage 2: chroma high term, hue offsets
	logic [11:0]          a_lo, a_hi;
	logic [TW-1:0]        h_val, red_sum;
	logic [CHROMA_W-1:0]  a_s2;
	logic [LIGHT_W-1:0]   light_s2;
	logic [TW-1:0]        t_s2 [N_CHAN];

	always_comb begin
		a_lo = 12'(light_s1) * 12'({1'b1, sat_s1});
		a_hi = (12'(light_s1) << 4) + (12'(sat_s1) << 7) - 12'(light_s1) * 12'(sat_s1);
		h_val = TW'({hue_s1, 1'b1}) << H_POS;
		red_sum = h_val + THIRD;
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			a_s2     <= light_s1[LIGHT_W-1] ? a_hi[CHROMA_W-1:0] : a_lo[CHROMA_W-1:0];
			light_s2 <= light_s1;
			t_s2[CH_RED]   <= (red_sum > ONE) ? red_sum - ONE : red_sum;
			t_s2[CH_GREEN] <= h_val;
			t_s2[CH_BLUE]  <= (h_val < THIRD) ? h_val + ONE - THIRD : h_val - THIRD;
		end
	end

	// stage 3: low term, segment select, multiplier operands
	logic [11:0]          b_wide;
	logic [CHROMA_W-1:0]  b_val, d_val;
	logic [TW+2:0]        t_x [N_CHAN];
	seg_t                 seg_c [N_CHAN];
	logic [OPX_W-1:0]     opx_c [N_CHAN];
	logic [TW-1:0]        opy_c [N_CHAN];
	logic [CHROMA_W-1:0]  a_s3, b_s3;
	seg_t                 seg_s3 [N_CHAN];
	logic [OPX_W-1:0]     opx_s3 [N_CHAN];
	logic [TW-1:0]        opy_s3 [N_CHAN];

	always_comb begin
		b_wide = (12'(light_s2) << 5) - 12'(a_s2);
		b_val  = b_wide[CHROMA_W-1:0];
		d_val  = a_s2 - b_val;
		for (int c = 0; c < N_CHAN; c++) begin
			t_x[c] = (TW+3)'(t_s2[c]);
			if ((t_x[c] << 2) + (t_x[c] << 1) < (TW+3)'(ONE)) begin
				seg_c[c] = SEG_RISE;
				opx_c[c] = (OPX_W'(d_val) << 2) + (OPX_W'(d_val) << 1);
				opy_c[c] = t_s2[c];
			end else if ((t_x[c] << 1) < (TW+3)'(ONE)) begin
				seg_c[c] = SEG_HIGH;
				opx_c[c] = '0;
				opy_c[c] = '0;
			end else if ((t_x[c] << 1) + t_x[c] < ((TW+3)'(ONE) << 1)) begin
				seg_c[c] = SEG_FALL;
				opx_c[c] = OPX_W'(d_val);
				opy_c[c] = (t_s2[c] <= TWO_THIRDS) ? TWO_THIRDS - t_s2[c] : '0;
			end else begin
				seg_c[c] = SEG_LOW;
				opx_c[c] = '0;
				opy_c[c] = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			a_s3 <= a_s2;
			b_s3 <= b_val;
			for (int c = 0; c < N_CHAN; c++) begin
				seg_s3[c] <= seg_c[c];
				opx_s3[c] <= opx_c[c];
				opy_s3[c] <= opy_c[c];
			end
		end
	end

	// stage 4: multiply, drop chroma unit bits
	logic [PROD_W-1:0]    prod_c [N_CHAN];
	logic [CHROMA_W-1:0]  a_s4, b_s4;
	seg_t                 seg_s4 [N_CHAN];
	logic [PQ_W-1:0]      pq_s4 [N_CHAN];

	always_comb begin
		for (int c = 0; c < N_CHAN; c++)
			prod_c[c] = PROD_W'(opx_s3[c]) * PROD_W'(opy_s3[c]);
	end

	always_ff @(posedge clk) begin
		if (adv4) begin
			a_s4 <= a_s3;
			b_s4 <= b_s3;
			for (int c = 0; c < N_CHAN; c++) begin
				seg_s4[c] <= seg_s3[c];
				pq_s4[c]  <= prod_c[c][PROD_W-1:UNIT_SHIFT];
			end
		end
	end

	// stage 5: add base, scale to byte, saturate
	logic [VW-1:0]      base_a, base_b;
	logic [VW-1:0]      val_c [N_CHAN];
	logic [VW-1:0]      byte_c [N_CHAN];
	logic [CHAN_W-1:0]  chan_s5 [N_CHAN];

	always_comb begin
		base_a = VW'(a_s4) << UNIT_POS;
		base_b = VW'(b_s4) << UNIT_POS;
		for (int c = 0; c < N_CHAN; c++) begin
			case (seg_s4[c])
				SEG_RISE: val_c[c] = base_b + VW'(pq_s4[c]);
				SEG_HIGH: val_c[c] = base_a;
				SEG_FALL: val_c[c] = base_b + (VW'(pq_s4[c]) << 2) + (VW'(pq_s4[c]) << 1);
				default:  val_c[c] = base_b;
			endcase
			byte_c[c] = val_c[c] >> BYTE_POS;
		end
	end

	always_ff @(posedge clk) begin
		if (adv5) begin
			for (int c = 0; c < N_CHAN; c++)
				chan_s5[c] <= (|byte_c[c][VW-1:CHAN_W]) ? '1 : byte_c[c][CHAN_W-1:0];
		end
	end

	assign rgb.red   = chan_s5[CH_RED];
	assign rgb.green = chan_s5[CH_GREEN];
	assign rgb.blue  = chan_s5[CH_BLUE];

endmodule
`default_nettype wire

[rtl/phr_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Packed HSL to RGB - port checker
// Watches the stream ports for output hold, reset, flow-through latency and black output.
// ----------------------------------------------------------------------------
module phr_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               hsl_valid,
	input logic                               hsl_ready,
	input logic [phr_pkg::COLOR_W-1:0]        color_word,
	input logic signed [phr_pkg::SHADE_W-1:0] shade_offset,
	input logic                               rgb_valid,
	input logic                               rgb_ready,
	input logic [phr_pkg::CHAN_W-1:0]         red,
	input logic [phr_pkg::CHAN_W-1:0]         green,
	input logic [phr_pkg::CHAN_W-1:0]         blue
);
	import phr_pkg::*;

	logic       in_acc;
	logic       black_in;
	logic signed [9:0] light_sum;

	assign in_acc    = hsl_valid && hsl_ready;
	assign light_sum = $signed({3'b000, color_word[LIGHT_W-1:0]})
		+ $signed({{2{shade_offset[SHADE_W-1]}}, shade_offset});
	assign black_in  = (light_sum <= 10'sd0);

	a_reset_empty: assert property (@(posedge clk) !arst_n |=> !rgb_valid)
		else $error("output word valid during reset");

	a_hold_word: assert property (@(posedge clk) disable iff (!arst_n)
		rgb_valid && !rgb_ready |=> rgb_valid && $stable({red, green, blue}))
		else $error("stalled output word changed or dropped");

	a_flow_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc ##1 rgb_ready ##1 rgb_ready ##1 rgb_ready ##1 rgb_ready |=> rgb_valid)
		else $error("word did not reach output after five free cycles");

	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && black_in ##1 rgb_ready ##1 rgb_ready ##1 rgb_ready ##1 rgb_ready
		|=> red == '0 && green == '0 && blue == '0)
		else $error("zero lightness did not give black");

endmodule

bind packed_hsl_to_rgb phr_checker u_phr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.hsl_valid    (hsl.valid),
	.hsl_ready    (hsl.ready),
	.color_word   (hsl.color_word),
	.shade_offset (hsl.shade_offset),
	.rgb_valid    (rgb.valid),
	.rgb_ready    (rgb.ready),
	.red          (rgb.red),
	.green        (rgb.green),
	.blue         (rgb.blue)
);
`default_nettype wire

[tb/sv/packed_hsl_to_rgb_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packed HSL to RGB - testbench
// Drives packed colour words with shade offsets into the converter. Each
// accepted word is turned into a predicted red, green and blue triple. Each
// result word leaving the block is checked against the oldest prediction.
// Directed corner words come first, then random words under varying idle
// patterns on both channels, then a long output stall that fills the pipeline.
// ----------------------------------------------------------------------------
module packed_hsl_to_rgb_tb;
	import phr_pkg::*;

	localparam int FB             = FRAC_BITS_DEF;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_WORDS   = 330;

	localparam logic [63:0] FX_ONE        = 64'd1 << FB;
	localparam logic [63:0] FX_HALF       = 64'd1 << (FB - 1);
	localparam logic [63:0] FX_THIRD      = FX_ONE / 3;
	localparam logic [63:0] FX_TWO_THIRDS = (64'd2 * FX_ONE) / 3;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} rgb_t;

	logic clk;
	logic arst_n;

	phr_in_if  hsl_if ();
	phr_out_if rgb_if ();

	packed_hsl_to_rgb dut (
		.clk    (clk),
		.arst_n (arst_n),
		.hsl    (hsl_if),
		.rgb    (rgb_if)
	);

	rgb_t expected_rgb[$];
	int   fail_count   = 0;
	int   src_idle_pct = 0;
	int   snk_idle_pct = 0;
	int   stall_left   = 0;
	int   quiet_cycles = 0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// Colour prediction
	// ------------------------------------------------------------------------
	function automatic logic [63:0] fixed_mul(input logic [63:0] x, input logic [63:0] y);
		logic [127:0] p;
		p = 128'(x) * 128'(y);
		return 64'(p >> FB);
	endfunction

	function automatic logic [63:0] ramp_level(input logic [63:0] t, input logic [63:0] a,
			input logic [63:0] b);
		logic [63:0] d;
		logic [63:0] rem;
		d = a - b;
		if (64'd6 * t < FX_ONE)
			return b + fixed_mul(64'd6 * d, t);
		if (64'd2 * t < FX_ONE)
			return a;
		if (64'd3 * t < 64'd2 * FX_ONE) begin
			rem = (t <= FX_TWO_THIRDS) ? (FX_TWO_THIRDS - t) : 64'd0;
			return b + 64'd6 * fixed_mul(d, rem);
		end
		return b;
	endfunction

	function automatic logic [CHAN_W-1:0] level_to_chan(input logic [63:0] v);
		logic [63:0] c;
		c = v >> (FB - 8);
		return (c > 64'd255) ? 8'd255 : c[7:0];
	endfunction

	function automatic rgb_t hsl_to_rgb_expect(input logic [COLOR_W-1:0] cw,
			input logic signed [SHADE_W-1:0] sh);
		logic [HUE_W-1:0] hue;
		logic [SAT_W-1:0] sat;
		int               lum;
		logic [63:0]      h, s, l, a, b, t_red, t_blue;
		rgb_t             r;
		hue = cw[HUE_LSB +: HUE_W];
		sat = cw[SAT_LSB +: SAT_W];
		lum = int'(cw[LIGHT_W-1:0]) + int'(sh);
		if (lum < 0)
			lum = 0;
		if (lum > 127)
			lum = 127;
		h = (64'(hue) * 2 + 64'd1) << (FB - 7);
		s = (64'(sat) * 2 + 64'd1) << (FB - 4);
		l = 64'(lum) << (FB - 7);
		if (l < FX_HALF)
			a = fixed_mul(l, FX_ONE + s);
		else
			a = (l + s) - fixed_mul(l, s);
		b = 64'd2 * l - a;
		t_red = h + FX_THIRD;
		if (t_red > FX_ONE)
			t_red = t_red - FX_ONE;
		t_blue = (h < FX_THIRD) ? (h + FX_ONE - FX_THIRD) : (h - FX_THIRD);
		r.red   = level_to_chan(ramp_level(t_red, a, b));
		r.green = level_to_chan(ramp_level(h, a, b));
		r.blue  = level_to_chan(ramp_level(t_blue, a, b));
		return r;
	endfunction

	function automatic logic [COLOR_W-1:0] pack_hsl(input int hue, input int sat, input int lum);
		return {6'(hue), 3'(sat), 7'(lum)};
	endfunction

	// ------------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------------
	task automatic send_word(input logic [COLOR_W-1:0] cw, input logic signed [SHADE_W-1:0] sh);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			hsl_if.valid <= 1'b0;
			@(negedge clk);
		end
		hsl_if.valid        <= 1'b1;
		hsl_if.color_word   <= cw;
		hsl_if.shade_offset <= sh;
		do
			@(posedge clk);
		while (!hsl_if.ready);
		expected_rgb.insert(expected_rgb.size(), hsl_to_rgb_expect(cw, sh));
	endtask

	task automatic drain;
		@(negedge clk);
		hsl_if.valid <= 1'b0;
		while (expected_rgb.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Output side: random hold-off, or a counted long stall on request
	// ------------------------------------------------------------------------
	initial begin
		rgb_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				rgb_if.ready <= 1'b0;
				stall_left = stall_left - 1;
			end else begin
				rgb_if.ready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	task automatic check_chan(input string name, input logic [CHAN_W-1:0] exp_v,
			input logic [CHAN_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		rgb_t exp_w;
		if (arst_n && rgb_if.valid && rgb_if.ready) begin
			if (expected_rgb.size() == 0) begin
				$display("%0t: unexpected word, expected none, got %0d %0d %0d", $time,
					rgb_if.red, rgb_if.green, rgb_if.blue);
				fail_count++;
			end else begin
				exp_w = expected_rgb.pop_front();
				check_chan("red", exp_w.red, rgb_if.red);
				check_chan("green", exp_w.green, rgb_if.green);
				check_chan("blue", exp_w.blue, rgb_if.blue);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (hsl_if.valid && hsl_if.ready) || (rgb_if.valid && rgb_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
			$display("packed_hsl_to_rgb_tb: FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	task automatic test_corners;
		send_word(pack_hsl(0, 0, 0), 8'sh00);
		send_word(pack_hsl(63, 7, 127), 8'sh00);
		send_word(pack_hsl(0, 7, 64), 8'sh00);
		send_word(pack_hsl(63, 0, 64), 8'sh00);
		send_word(pack_hsl(21, 3, 40), 8'sh00);
		send_word(pack_hsl(42, 5, 90), 8'sh00);
		send_word(pack_hsl(10, 2, 30), 8'sh80);
		send_word(pack_hsl(50, 6, 100), 8'sh7F);
		send_word(pack_hsl(32, 4, 127), 8'sh80);
		send_word(pack_hsl(5, 1, 0), 8'sh7F);
		send_word(pack_hsl(16, 7, 63), 8'sh00);
		send_word(pack_hsl(16, 7, 64), 8'sh00);
		send_word(16'hFFFF, 8'shFF);
		send_word(16'h0000, 8'sh7F);
		send_word(pack_hsl(20, 3, 70), 8'sh00);
		send_word(pack_hsl(22, 3, 70), 8'sh00);
		send_word(pack_hsl(43, 6, 50), 8'sh00);
		send_word(pack_hsl(31, 2, 10), 8'sh05);
		send_word(pack_hsl(48, 7, 100), -8'sd30);
		send_word(pack_hsl(8, 0, 127), 8'sh00);
		send_word(16'h8000, 8'sh80);
		send_word(16'h5555, 8'sh55);
		send_word(16'hAAAA, 8'shAA);
		drain();
	endtask

	task automatic test_random(input int n_words);
		logic [COLOR_W-1:0]        cw;
		logic signed [SHADE_W-1:0] sh;
		for (int i = 0; i < n_words; i++) begin
			cw = 16'($urandom_range(0, 65535));
			// keep most shades small so lightness is seldom clamped
			if ($urandom_range(99) < 70)
				sh = 8'($urandom_range(0, 32)) - 8'sd16;
			else
				sh = 8'($urandom_range(0, 255));
			send_word(cw, sh);
		end
		drain();
	endtask

	task automatic test_output_stall;
		src_idle_pct = 0;
		snk_idle_pct = 0;
		stall_left   = 300;
		for (int i = 0; i < 40; i++)
			send_word(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
		drain();
	endtask

	initial begin
		arst_n              = 1'b0;
		hsl_if.valid        = 1'b0;
		hsl_if.color_word   = '0;
		hsl_if.shade_offset = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		src_idle_pct = 18;
		snk_idle_pct = 53;
		test_corners();
		test_random(RANDOM_WORDS);

		src_idle_pct = 53;
		snk_idle_pct = 18;
		test_random(RANDOM_WORDS);

		src_idle_pct = 0;
		snk_idle_pct = 0;
		test_random(RANDOM_WORDS);

		test_output_stall();

		if (fail_count == 0)
			$display("packed_hsl_to_rgb_tb: PASS");
		else
			$display("packed_hsl_to_rgb_tb: FAIL");
		$finish;
	end

endmodule
